// ===== hdl/hse_pkg.sv =====
`default_nettype none

package hse_pkg;

    // Field widths
    localparam int SPEED_W    = 22;
    localparam int TIME_W     = 32;
    localparam int HALL_W     = 3;
    localparam int TICKS_W    = 8;
    localparam int RATIO_W    = 8;
    localparam int MININT_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Divider geometry: dividend is the speed scale or the history sum, divisor is ticks * interval or the fill count
    localparam int DVD_W  = 34;
    localparam int DEN_W  = TICKS_W + TIME_W;
    localparam int PROD_W = SPEED_W + RATIO_W;
    localparam int CNT_W  = $clog2(DVD_W + 1);

    localparam logic [DVD_W-1:0] SCALE_RPM = 34'd15360000000;
    localparam logic [DVD_W-1:0] SCALE_RPS = 34'd256000000;

    localparam int DEFAULT_HISTORY_DEPTH = 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EDGES_PER_REV = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RPM_UNITS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTLIER_RATIO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT       = 3'd5;

    // Register reset values
    localparam logic [TICKS_W-1:0]  RST_EDGES_PER_REV = 8'd6;
    localparam logic                RST_RPM_UNITS     = 1'b1;
    localparam logic [SPEED_W-1:0]  RST_MAX_SPEED     = 22'd2560000;
    localparam logic [RATIO_W-1:0]  RST_OUTLIER_RATIO = 8'd30;
    localparam logic [MININT_W-1:0] RST_MIN_INTERVAL  = 16'd10;
    localparam logic [TIME_W-1:0]   RST_TIMEOUT       = 32'd500000;

    // Event codes
    localparam logic ACT_EDGE    = 1'b0;
    localparam logic ACT_TIMEOUT = 1'b1;

    typedef struct packed {
        logic              action;
        logic [TIME_W-1:0] time_us;
        logic [HALL_W-1:0] hall_bits;
    } t_in_item;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic [HALL_W-1:0]  hall_now;
        logic               hall_changed;
        logic               speed_cleared;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV_RAW,
        S_SELECT,
        S_UPDATE,
        S_DIV_AVG,
        S_TIMEOUT,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/hall_speed_estimator.sv =====
`default_nettype none

// Hall sensor speed estimator. Each input transfer is either a hall edge
// (timestamp in microseconds plus voted hall bits) or a timeout check, and
// each one yields exactly one result transfer carrying the filtered speed
// (unsigned, 8 fraction bits), the stored hall state and two event flags.
// On an edge the interval since the previous edge (mod 2^32, raised to
// min_interval_us) times edges_per_rev divides the rpm or rev/s scale; the
// raw speed falls back to the current filtered speed when it is an outlier
// or above max_speed, enters a ring of HISTORY_DEPTH entries, and the
// filtered speed becomes the truncated mean of the filled entries. All
// division runs on one shared restoring divider, one quotient bit per cycle;
// the raw speed divides a 34-bit dividend and the mean the SUM_W-bit sum,
// where SUM_W = 22 + clog2(HISTORY_DEPTH). An edge passes through prepare,
// raw division, select, update, mean division and done; a timeout check
// passes through the timeout state and done. The input stalls while an item
// is in work and the next input can transfer once the block is idle again;
// a finished result waits in the output register, so the next input can
// transfer while the previous result is still stalled downstream. An item
// that finishes while that earlier result still waits holds in its last
// state until the result transfers. Config registers are written through a
// plain write port; the user must write them only while the block is idle,
// and the block itself does not enforce it.
module hall_speed_estimator
    import hse_pkg::*;
#(
    parameter int HISTORY_DEPTH = DEFAULT_HISTORY_DEPTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input item channel
    input  wire logic                  i_in_valid,
    output      logic                  o_in_stall,
    input  wire t_in_item              i_in_item,
    // result channel
    output      logic                  o_out_valid,
    input  wire logic                  i_out_stall,
    output      t_out_item             o_out_item,
    // config write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W  = SPEED_W + $clog2(HISTORY_DEPTH);

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [TICKS_W-1:0]  r_ticks;
    logic                r_rpm;
    logic [SPEED_W-1:0]  r_max;
    logic [RATIO_W-1:0]  r_ratio;
    logic [MININT_W-1:0] r_min_int;
    logic [TIME_W-1:0]   r_timeout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks   <= RST_EDGES_PER_REV;
            r_rpm     <= RST_RPM_UNITS;
            r_max     <= RST_MAX_SPEED;
            r_ratio   <= RST_OUTLIER_RATIO;
            r_min_int <= RST_MIN_INTERVAL;
            r_timeout <= RST_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EDGES_PER_REV: r_ticks   <= i_cfg_data[TICKS_W-1:0];
                CFG_RPM_UNITS:     r_rpm     <= i_cfg_data[0];
                CFG_MAX_SPEED:     r_max     <= i_cfg_data[SPEED_W-1:0];
                CFG_OUTLIER_RATIO: r_ratio   <= i_cfg_data[RATIO_W-1:0];
                CFG_MIN_INTERVAL:  r_min_int <= i_cfg_data[MININT_W-1:0];
                CFG_TIMEOUT:       r_timeout <= i_cfg_data;
                default: ;  // unknown index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    t_state              r_state,  n_state;
    logic [TIME_W-1:0]   r_last,   n_last;
    logic [SPEED_W-1:0]  r_filt,   n_filt;
    logic [SLOT_W-1:0]   r_slot,   n_slot;
    logic [FILL_W-1:0]   r_fill,   n_fill;
    logic [SUM_W-1:0]    r_sum,    n_sum;
    logic [HALL_W-1:0]   r_hall,   n_hall;
    logic                r_out_valid, n_out_valid;
    logic [CNT_W-1:0]    r_cnt,    n_cnt;

    // working registers of the current item
    logic                r_action,  n_action;
    logic [TIME_W-1:0]   r_time,    n_time;
    logic [HALL_W-1:0]   r_hall_in, n_hall_in;
    logic                r_changed, n_changed;
    logic                r_cleared, n_cleared;
    logic [PROD_W-1:0]   r_prod,    n_prod;
    logic [SPEED_W-1:0]  r_sel,     n_sel;
    t_out_item           r_out,     n_out;

    // shared divider
    logic [DVD_W-1:0]    r_quo, n_quo;
    logic [DEN_W-1:0]    r_rem, n_rem;
    logic [DEN_W-1:0]    r_div, n_div;

    // ring buffer
    logic [SPEED_W-1:0]  r_mem [HISTORY_DEPTH];
    logic [SPEED_W-1:0]  r_rd_data;

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic                in_xfer;
    logic [TIME_W-1:0]   w_elapsed;
    logic [TIME_W-1:0]   w_min_int;
    logic [TIME_W-1:0]   w_interval;
    logic [TICKS_W-1:0]  w_ticks;
    logic [DEN_W:0]      w_trial;
    logic [DEN_W:0]      w_diff;
    logic                w_fit;
    logic                w_full;
    logic [SUM_W-1:0]    w_sum_upd;
    logic [FILL_W-1:0]   w_fill_upd;
    logic                w_reject;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;

    assign w_elapsed  = r_time - r_last;
    assign w_min_int  = (r_min_int == '0) ? TIME_W'(1) : TIME_W'(r_min_int);
    assign w_interval = (w_elapsed < w_min_int) ? w_min_int : w_elapsed;
    assign w_ticks    = (r_ticks == '0) ? TICKS_W'(1) : r_ticks;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign w_trial = {r_rem, r_quo[DVD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_fit   = !w_diff[DEN_W];

    // outlier or over-limit raw speed falls back to the filtered speed
    assign w_reject = ((r_filt != '0) && (r_quo > DVD_W'(r_prod))) ||
                      (r_quo > DVD_W'(r_max));

    assign w_full     = (r_fill == FILL_W'(HISTORY_DEPTH));
    assign w_sum_upd  = r_sum - (w_full ? SUM_W'(r_rd_data) : SUM_W'(0)) + SUM_W'(r_sel);
    assign w_fill_upd = w_full ? r_fill : r_fill + 1'b1;

    always_comb begin
        n_state     = r_state;
        n_last      = r_last;
        n_filt      = r_filt;
        n_slot      = r_slot;
        n_fill      = r_fill;
        n_sum       = r_sum;
        n_hall      = r_hall;
        n_out_valid = r_out_valid;
        n_cnt       = r_cnt;
        n_action    = r_action;
        n_time      = r_time;
        n_hall_in   = r_hall_in;
        n_changed   = r_changed;
        n_cleared   = r_cleared;
        n_prod      = r_prod;
        n_sel       = r_sel;
        n_out       = r_out;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_div       = r_div;

        // result taken downstream
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_action  = i_in_item.action;
                    n_time    = i_in_item.time_us;
                    n_hall_in = i_in_item.hall_bits;
                    n_changed = 1'b0;
                    n_cleared = 1'b0;
                    n_state   = (i_in_item.action == ACT_TIMEOUT) ? S_TIMEOUT : S_PREP;
                end
            end
            S_PREP: begin
                // load the divider with scale / (ticks * interval)
                n_div   = DEN_W'(w_ticks) * DEN_W'(w_interval);
                n_prod  = PROD_W'(r_filt) * PROD_W'(r_ratio);
                n_quo   = r_rpm ? SCALE_RPM : SCALE_RPS;
                n_rem   = '0;
                n_cnt   = CNT_W'(DVD_W);
                n_last  = r_time;
                n_state = S_DIV_RAW;
            end
            S_DIV_RAW, S_DIV_AVG: begin
                n_rem = w_fit ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                n_quo = {r_quo[DVD_W-2:0], w_fit};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    n_state = (r_state == S_DIV_RAW) ? S_SELECT : S_DONE;
                end
            end
            S_SELECT: begin
                n_sel   = w_reject ? r_filt : r_quo[SPEED_W-1:0];
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                // ring write happens in the memory block; start the mean division
                n_sum  = w_sum_upd;
                n_fill = w_fill_upd;
                n_slot = (r_slot == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : r_slot + 1'b1;
                if (r_hall_in != r_hall) begin
                    n_hall    = r_hall_in;
                    n_changed = 1'b1;
                end
                n_quo   = {w_sum_upd, {(DVD_W - SUM_W){1'b0}}};
                n_rem   = '0;
                n_div   = DEN_W'(w_fill_upd);
                n_cnt   = CNT_W'(SUM_W);
                n_state = S_DIV_AVG;
            end
            S_TIMEOUT: begin
                if (w_elapsed > r_timeout) begin
                    n_filt    = '0;
                    n_sum     = '0;
                    n_fill    = '0;
                    n_slot    = '0;
                    n_cleared = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out.speed         = (r_action == ACT_EDGE) ? r_quo[SPEED_W-1:0] : r_filt;
                    n_out.hall_now      = r_hall;
                    n_out.hall_changed  = r_changed;
                    n_out.speed_cleared = r_cleared;
                    if (r_action == ACT_EDGE) begin
                        n_filt = r_quo[SPEED_W-1:0];
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= '0;
            r_filt      <= '0;
            r_slot      <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_hall      <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_filt      <= n_filt;
            r_slot      <= n_slot;
            r_fill      <= n_fill;
            r_sum       <= n_sum;
            r_hall      <= n_hall;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    // payload and divider registers
    always_ff @(posedge i_clk) begin
        r_action  <= n_action;
        r_time    <= n_time;
        r_hall_in <= n_hall_in;
        r_changed <= n_changed;
        r_cleared <= n_cleared;
        r_prod    <= n_prod;
        r_sel     <= n_sel;
        r_out     <= n_out;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_div     <= n_div;
    end

    // history ring: registered read of the slot about to be replaced
    always_ff @(posedge i_clk) begin
        if (r_state == S_UPDATE) begin
            r_mem[r_slot] <= r_sel;
        end
        r_rd_data <= r_mem[r_slot];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(HISTORY_DEPTH))
        else $error("history fill count beyond depth");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0) |-> (r_filt == '0 && r_sum == '0 && r_slot == '0))
        else $error("empty history with nonzero speed or sum");

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DIV_RAW && r_state != S_DIV_AVG) |-> (r_cnt == '0))
        else $error("divider count running outside a division");

    a_xfer_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_PREP || r_state == S_TIMEOUT))
        else $error("accepted item did not start work");

    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && n_state == S_IDLE) |=> r_out_valid)
        else $error("finished item produced no result");

endmodule

`default_nettype wire
